// ===== rtl/core/tcw_pkg.sv =====
// shared types and constants for the text console character writer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package tcw_pkg;

	// default screen geometry
	localparam int DEF_SCREEN_COLUMNS = 80;
	localparam int DEF_SCREEN_ROWS    = 25;

	// fixed port widths
	localparam int OP_W        = 2;
	localparam int CHAR_W      = 8;
	localparam int INDEX_W     = 11;
	localparam int LOC_W       = 11;
	localparam int CELL_W      = 16;
	localparam int COLOUR_W    = 4;
	localparam int CFG_INDEX_W = 1;

	typedef enum logic [OP_W-1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FOREGROUND = 1'b0,
		REG_BACKGROUND = 1'b1
	} reg_index_t;

	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_PRINT_MIN = 8'h20;

	localparam int TAB_STEP = 8;

	// white on black space for the row that scrolls in
	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

	localparam logic [COLOUR_W-1:0] FG_RESET = 4'd2;
	localparam logic [COLOUR_W-1:0] BG_RESET = 4'd0;

	typedef struct packed {
		logic wr;
		logic scroll;
	} put_flags_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_FILL
	} state_t;

endpackage

// ===== rtl/core/tcw_cursor.sv =====
// cursor update for one put byte: control codes, printable advance, wrap, scroll
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_cursor #(
	parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
	parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS,
	parameter int CW             = $clog2(SCREEN_COLUMNS + 8),
	parameter int RW             = $clog2(SCREEN_ROWS + 1),
	parameter int LW             = $clog2(SCREEN_COLUMNS * SCREEN_ROWS + 1)
) (
	input  logic [CW-1:0]                col,
	input  logic [RW-1:0]                row,
	input  logic [LW-1:0]                loc,
	input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
	output logic [CW-1:0]                col_next,
	output logic [RW-1:0]                row_next,
	output logic [LW-1:0]                loc_next,
	output tcw_pkg::put_flags_t          flags
);
	import tcw_pkg::*;

	logic [LW-1:0] line_start_next;

	// start of the following row, used by line feed and by row-end wrap
	assign line_start_next = loc - LW'(col) + LW'(SCREEN_COLUMNS);

	always_comb begin
		col_next = col;
		row_next = row;
		loc_next = loc;
		flags    = '0;

		case (char_code)
			CH_BACKSPACE: begin
				if (col != '0) begin
					col_next = col - 1'b1;
					loc_next = loc - 1'b1;
				end
			end
			CH_TAB: begin
				col_next = (col + CW'(TAB_STEP)) & ~CW'(TAB_STEP - 1);
				loc_next = loc + LW'(TAB_STEP) - LW'(col & CW'(TAB_STEP - 1));
			end
			CH_CR: begin
				col_next = '0;
				loc_next = loc - LW'(col);
			end
			CH_LF: begin
				col_next = '0;
				row_next = row + 1'b1;
				loc_next = line_start_next;
			end
			default: begin
				if (char_code >= CH_PRINT_MIN) begin
					flags.wr = 1'b1;
					col_next = col + 1'b1;
					loc_next = loc + 1'b1;
				end
			end
		endcase

		if (col_next >= CW'(SCREEN_COLUMNS)) begin
			col_next = '0;
			row_next = row + 1'b1;
			loc_next = line_start_next;
		end

		// ran off the bottom: cursor parks at the start of the last row
		if (row_next == RW'(SCREEN_ROWS)) begin
			row_next     = RW'(SCREEN_ROWS - 1);
			loc_next     = LW'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);
			flags.scroll = 1'b1;
		end
	end

endmodule

// ===== rtl/core/text_console_char_writer_core.sv =====
// text console core: screen memory, cursor, put / clear / read sequencer
// depends on tcw_pkg and tcw_cursor
// sequencing: put writes its cell from idle, read passes through ST_READ, a put that
// scrolls runs ST_SCROLL then ST_FILL, clear runs ST_SWEEP; one item in flight, taken in ST_IDLE
// reset: cursor home, colours 2/0, then a clearing pass over every cell with in_stall high
`timescale 1ns / 1ps

module text_console_char_writer_core #(
	parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
	parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tcw_pkg::COLOUR_W-1:0]    cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [tcw_pkg::OP_W-1:0]        operation,
	input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
	input  logic [tcw_pkg::INDEX_W-1:0]     cell_index,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tcw_pkg::LOC_W-1:0]       cursor_location,
	output logic [tcw_pkg::CELL_W-1:0]      read_data
);
	import tcw_pkg::*;

	localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int AW         = $clog2(CELL_COUNT);
	localparam int LW         = $clog2(CELL_COUNT + 1);
	localparam int CW         = $clog2(SCREEN_COLUMNS + 8);
	localparam int RW         = $clog2(SCREEN_ROWS + 1);

	localparam logic [AW-1:0] LAST_CELL   = AW'(CELL_COUNT - 1);
	localparam logic [AW-1:0] ROW_STRIDE  = AW'(SCREEN_COLUMNS);
	localparam logic [AW-1:0] BOTTOM_ROW  = AW'(CELL_COUNT - SCREEN_COLUMNS);

	state_t state_q, state_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic reply_q, reply_d;

	logic [CW-1:0] col_q, col_d, cur_col_nx;
	logic [RW-1:0] row_q, row_d, cur_row_nx;
	logic [LW-1:0] loc_q, loc_d, cur_loc_nx;
	put_flags_t cur_flags;

	logic [COLOUR_W-1:0] fg_q, bg_q;

	logic [CELL_W-1:0] screen_q [CELL_COUNT];
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [CELL_W-1:0] mem_wdata, mem_rdata_s1;
	logic              rd_ok_d, rd_ok_s1;

	// scroll copy pipeline: read row below, write it one row up from the registered read data
	logic          cp_valid_s1, cp_valid_d;
	logic [AW-1:0] cp_dst_s1, cp_dst_d;

	logic              out_valid_q, load_out;
	logic [LOC_W-1:0]  cursor_location_q;
	logic [CELL_W-1:0] read_data_q, out_data_d;

	logic in_accept, out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == ST_IDLE) && out_free);
	assign in_accept = in_valid && !in_stall;

	assign out_valid       = out_valid_q;
	assign cursor_location = cursor_location_q;
	assign read_data       = read_data_q;

	tcw_cursor #(
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS),
		.CW             (CW),
		.RW             (RW),
		.LW             (LW)
	) u_cursor (
		.col       (col_q),
		.row       (row_q),
		.loc       (loc_q),
		.char_code (char_code),
		.col_next  (cur_col_nx),
		.row_next  (cur_row_nx),
		.loc_next  (cur_loc_nx),
		.flags     (cur_flags)
	);

	always_comb begin
		state_d    = state_q;
		ptr_d      = ptr_q;
		reply_d    = reply_q;
		col_d      = col_q;
		row_d      = row_q;
		loc_d      = loc_q;
		mem_we     = 1'b0;
		mem_waddr  = ptr_q;
		mem_wdata  = '0;
		mem_re     = 1'b0;
		mem_raddr  = ptr_q;
		rd_ok_d    = 1'b0;
		cp_valid_d = 1'b0;
		cp_dst_d   = ptr_q - ROW_STRIDE;
		load_out   = 1'b0;
		out_data_d = '0;

		case (state_q)
			ST_SWEEP: begin
				mem_we = 1'b1;
				if (ptr_q == LAST_CELL) begin
					state_d  = ST_IDLE;
					reply_d  = 1'b0;
					load_out = reply_q;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (in_accept) begin
					case (op_t'(operation))
						OP_PUT: begin
							col_d = cur_col_nx;
							row_d = cur_row_nx;
							loc_d = cur_loc_nx;
							if (cur_flags.wr) begin
								mem_we    = 1'b1;
								mem_waddr = AW'(loc_q);
								mem_wdata = {bg_q, fg_q, char_code};
							end
							if (cur_flags.scroll) begin
								state_d = ST_SCROLL;
								ptr_d   = ROW_STRIDE;
							end else begin
								load_out = 1'b1;
							end
						end
						OP_CLEAR: begin
							col_d   = '0;
							row_d   = '0;
							loc_d   = '0;
							ptr_d   = '0;
							reply_d = 1'b1;
							state_d = ST_SWEEP;
						end
						OP_READ: begin
							mem_re    = 1'b1;
							mem_raddr = AW'(cell_index);
							rd_ok_d   = 32'(cell_index) < CELL_COUNT;
							state_d   = ST_READ;
						end
						default: begin
							load_out = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				load_out   = 1'b1;
				out_data_d = rd_ok_s1 ? mem_rdata_s1 : '0;
				state_d    = ST_IDLE;
			end
			ST_SCROLL: begin
				mem_re     = 1'b1;
				cp_valid_d = 1'b1;
				if (ptr_q == LAST_CELL) begin
					state_d = ST_FILL;
					ptr_d   = BOTTOM_ROW;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			ST_FILL: begin
				// first cycle still retires the last copy
				if (!cp_valid_s1) begin
					mem_we    = 1'b1;
					mem_wdata = BLANK_CELL;
					if (ptr_q == LAST_CELL) begin
						state_d  = ST_IDLE;
						load_out = 1'b1;
					end else begin
						ptr_d = ptr_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (cp_valid_s1) begin
			mem_we    = 1'b1;
			mem_waddr = cp_dst_s1;
			mem_wdata = mem_rdata_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			ptr_q       <= '0;
			reply_q     <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			loc_q       <= '0;
			cp_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ptr_q       <= ptr_d;
			reply_q     <= reply_d;
			col_q       <= col_d;
			row_q       <= row_d;
			loc_q       <= loc_d;
			cp_valid_s1 <= cp_valid_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= FG_RESET;
			bg_q <= BG_RESET;
		end else if (cfg_write_en) begin
			case (reg_index_t'(cfg_index))
				REG_FOREGROUND: fg_q <= cfg_data;
				REG_BACKGROUND: bg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			cursor_location_q <= LOC_W'(loc_d);
			read_data_q       <= out_data_d;
		end
		cp_dst_s1 <= cp_dst_d;
	end

	// screen memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			screen_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_s1 <= screen_q[mem_raddr];
			rd_ok_s1     <= rd_ok_d;
		end
	end

endmodule

// ===== rtl/core/tcw_checker.sv =====
// port-level checks for the text console core, attached by bind
// depends on tcw_pkg and text_console_char_writer_core
`timescale 1ns / 1ps

module tcw_checker #(
	parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
	parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic [tcw_pkg::OP_W-1:0]        operation,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [tcw_pkg::LOC_W-1:0]       cursor_location,
	input logic [tcw_pkg::CELL_W-1:0]      read_data
);
	import tcw_pkg::*;

	localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;

	logic in_beat;
	assign in_beat = in_valid && !in_stall;

	// a held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cursor_location) && $stable(read_data))
		else $error("result beat changed while stalled");

	// cursor never points off screen when the location fits the port
	a_loc_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (CELL_COUNT > 2048) || (32'(cursor_location) < CELL_COUNT))
		else $error("cursor location beyond the screen");

	// read and clear occupy the memory, so no beat is taken right after
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && (operation == OP_READ || operation == OP_CLEAR) |=> in_stall)
		else $error("input taken while memory sequence runs");

	// read result becomes valid after the ST_READ state loads the result register
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && operation == OP_READ |-> ##2 out_valid)
		else $error("read result missing");

endmodule

bind text_console_char_writer_core tcw_checker #(
	.SCREEN_COLUMNS (SCREEN_COLUMNS),
	.SCREEN_ROWS    (SCREEN_ROWS)
) u_tcw_checker (.*);

// ===== bench/tcw_shadow_pkg.sv =====
// shadow copy of the console screen and cursor, plus the queue of owed result beats
// depends on tcw_pkg; used by the testbench top
`timescale 1ns / 1ps

package tcw_shadow_pkg;
	import tcw_pkg::*;

	localparam int COLS  = DEF_SCREEN_COLUMNS;
	localparam int ROWS  = DEF_SCREEN_ROWS;
	localparam int CELLS = COLS * ROWS;

	// operation code the block has no use for
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [LOC_W-1:0]  loc;
		logic [CELL_W-1:0] data;
	} console_beat_t;

	// mostly back to back, some short gaps, a few long ones
	function automatic int idle_length(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	class screen_shadow;
		logic [CELL_W-1:0]   cells [CELLS];
		int                  col;
		int                  row;
		logic [COLOUR_W-1:0] fg;
		logic [COLOUR_W-1:0] bg;
		console_beat_t       owed_beats [$];
		int                  errors;

		function new();
			wipe();
			fg     = FG_RESET;
			bg     = BG_RESET;
			errors = 0;
		endfunction

		function void wipe();
			foreach (cells[i])
				cells[i] = '0;
			col = 0;
			row = 0;
		endfunction

		function int cursor_now();
			return row * COLS + col;
		endfunction

		function void scroll_up();
			for (int i = 0; i < CELLS - COLS; i++)
				cells[i] = cells[i + COLS];
			for (int i = CELLS - COLS; i < CELLS; i++)
				cells[i] = BLANK_CELL;
			row = ROWS - 1;
		endfunction

		function void put_char(logic [CHAR_W-1:0] c);
			case (c)
				CH_BACKSPACE: if (col > 0) col--;
				CH_TAB:       col = (col + TAB_STEP) & ~(TAB_STEP - 1);
				CH_CR:        col = 0;
				CH_LF: begin
					col = 0;
					row++;
				end
				default: ;
			endcase
			if (c >= CH_PRINT_MIN) begin
				cells[row * COLS + col] = {bg, fg, c};
				col++;
			end
			if (col >= COLS) begin
				col = 0;
				row++;
			end
			if (row >= ROWS)
				scroll_up();
		endfunction

		// apply one accepted input beat and queue the beat it owes
		function void note_item(logic [OP_W-1:0] op, logic [CHAR_W-1:0] c,
				logic [INDEX_W-1:0] idx);
			console_beat_t b;
			b.data = '0;
			case (op)
				OP_PUT:   put_char(c);
				OP_CLEAR: wipe();
				OP_READ:  if (idx < CELLS) b.data = cells[idx];
				default: ;
			endcase
			b.loc = LOC_W'(cursor_now());
			owed_beats.push_back(b);
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 40)
				$display("ERROR @%0t: %s", $realtime, msg);
		endfunction

		function void check_beat(logic [LOC_W-1:0] loc, logic [CELL_W-1:0] data);
			console_beat_t want;
			if (owed_beats.size() == 0) begin
				report($sformatf("result beat with none owed: loc %0d data %h", loc, data));
				return;
			end
			want = owed_beats.pop_front();
			if (loc !== want.loc)
				report($sformatf("cursor_location %0d, want %0d", loc, want.loc));
			if (data !== want.data)
				report($sformatf("read_data %h, want %h", data, want.data));
		endfunction
	endclass

endpackage

// ===== bench/testbench.sv =====
// stimulus and checking for text_console_char_writer_core: directed puts, reads and
// clears, then random text with scrolls under several colour settings
// depends on tcw_pkg and tcw_shadow_pkg
`timescale 1ns / 1ps

module testbench;
	import tcw_pkg::*;
	import tcw_shadow_pkg::*;

	localparam int DRAIN_CYCLES   = 2100;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int MAX_INDEX      = (1 << INDEX_W) - 1;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [COLOUR_W-1:0]    cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic [OP_W-1:0]        operation;
	logic [CHAR_W-1:0]      char_code;
	logic [INDEX_W-1:0]     cell_index;
	logic                   out_valid;
	logic                   out_stall;
	logic [LOC_W-1:0]       cursor_location;
	logic [CELL_W-1:0]      read_data;

	screen_shadow shadow = new();
	int           items_sent = 0;
	int           idle_cycles = 0;

	text_console_char_writer_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.char_code      (char_code),
		.cell_index     (cell_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cursor_location(cursor_location),
		.read_data      (read_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] c,
			input logic [INDEX_W-1:0] idx);
		int gap;
		operation  <= op;
		char_code  <= c;
		cell_index <= idx;
		in_valid   <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		shadow.note_item(op, c, idx);
		items_sent++;
		gap = idle_length(((items_sent / 32) % 4) == 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic random_item(input int lf_pct);
		int                 r;
		int                 near;
		int                 back;
		logic [OP_W-1:0]    op;
		logic [CHAR_W-1:0]  c;
		logic [INDEX_W-1:0] idx;
		r   = $urandom_range(0, 999);
		c   = CHAR_W'($urandom);
		idx = INDEX_W'($urandom);
		if (r < 10) begin
			op = OP_CLEAR;
		end else if (r < 30) begin
			op = OP_UNUSED;
		end else if (r < 180) begin
			op = OP_READ;
			r  = $urandom_range(0, 99);
			if (r < 50) begin
				// just behind the cursor, where the fresh characters are
				back = $urandom_range(0, 8);
				near = shadow.cursor_now() - back;
				idx  = (near < 0) ? '0 : INDEX_W'(near);
			end else if (r < 85) begin
				idx = INDEX_W'($urandom_range(0, CELLS - 1));
			end else if (r < 95) begin
				idx = INDEX_W'($urandom_range(CELLS, MAX_INDEX));
			end else begin
				idx = INDEX_W'(CELLS - 1);
			end
		end else begin
			op = OP_PUT;
			r  = $urandom_range(0, 99);
			if (r < lf_pct)
				c = CH_LF;
			else if (r < lf_pct + 4)
				c = CH_CR;
			else if (r < lf_pct + 11)
				c = CH_TAB;
			else if (r < lf_pct + 18)
				c = CH_BACKSPACE;
			else if (r < lf_pct + 24)
				c = CHAR_W'($urandom_range(0, CH_PRINT_MIN - 1));
			else
				c = CHAR_W'($urandom_range(CH_PRINT_MIN, 255));
		end
		send_item(op, c, idx);
	endtask

	// stop offering and wait for every owed beat
	task automatic settle();
		in_valid <= 1'b0;
		while (shadow.owed_beats.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_colours(input logic [COLOUR_W-1:0] fg, input logic [COLOUR_W-1:0] bg);
		cfg_write_en <= 1'b1;
		cfg_index    <= REG_FOREGROUND;
		cfg_data     <= fg;
		@(posedge clk);
		cfg_index    <= REG_BACKGROUND;
		cfg_data     <= bg;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		shadow.fg = fg;
		shadow.bg = bg;
	endtask

	initial begin : stimulus
		logic [COLOUR_W-1:0] fg;
		logic [COLOUR_W-1:0] bg;
		arst_n       <= 1'b0;
		cfg_write_en <= 1'b0;
		cfg_index    <= REG_FOREGROUND;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		operation    <= OP_PUT;
		char_code    <= '0;
		cell_index   <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, reset colours
		send_item(OP_READ, 8'h00, '0);
		send_item(OP_READ, 8'hFF, INDEX_W'(CELLS - 1));
		send_item(OP_READ, 8'h00, INDEX_W'(MAX_INDEX));
		send_item(OP_READ, 8'h00, INDEX_W'(CELLS));
		send_item(OP_UNUSED, 8'h41, INDEX_W'(5));
		send_item(OP_PUT, CH_BACKSPACE, '0);
		send_item(OP_PUT, CH_PRINT_MIN, '0);
		send_item(OP_PUT, 8'hFF, '0);
		send_item(OP_PUT, 8'h7F, '0);
		send_item(OP_PUT, 8'h00, '0);
		send_item(OP_PUT, 8'h1F, '0);
		send_item(OP_PUT, CH_BACKSPACE, '0);
		// backspace leaves the cell alone
		send_item(OP_READ, 8'h00, INDEX_W'(1));
		send_item(OP_PUT, CH_TAB, '0);
		send_item(OP_PUT, 8'h55, '0);
		send_item(OP_READ, 8'h00, INDEX_W'(8));
		send_item(OP_PUT, CH_CR, '0);
		send_item(OP_PUT, CH_LF, '0);
		send_item(OP_PUT, 8'h0B, '0);
		send_item(OP_PUT, 8'hAA, '0);
		send_item(OP_READ, 8'h00, INDEX_W'(COLS));
		send_item(OP_CLEAR, 8'h20, '0);
		send_item(OP_READ, 8'h00, '0);

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin fg = 4'hF; bg = 4'hF; end
				1: begin fg = 4'h0; bg = 4'h0; end
				2: begin fg = 4'hF; bg = 4'h0; end
				3: begin fg = 4'h0; bg = 4'hF; end
				default: begin
					fg = COLOUR_W'($urandom);
					bg = COLOUR_W'($urandom);
				end
			endcase
			settle();
			write_colours(fg, bg);
			// odd phases run long lines so rows wrap on their own
			repeat (117) random_item((phase % 2) ? 2 : 10);
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (shadow.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : result_sink
		int stall_left;
		bit held_long;
		int cycle_count;
		stall_left  = 0;
		held_long   = 0;
		cycle_count = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (arst_n && out_valid && !out_stall)
				shadow.check_beat(cursor_location, read_data);
			if (stall_left > 0) begin
				stall_left--;
			end else if (!held_long && items_sent >= 150) begin
				// long hold-off so the block backs up onto its input
				held_long  = 1;
				stall_left = 400;
			end else begin
				stall_left = idle_length(((cycle_count / 256) % 4) == 1);
			end
			out_stall <= (stall_left > 0);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule
